// ===== rtl/core/tmx_pkg.sv =====
// Shared types and constants for the ticket mutual exclusion node.
// Used by the controller, the datapath, the top level and the checker.
`default_nettype none

package tmx_pkg;

    // Node ids are four bits, so at most sixteen nodes can be addressed.
    localparam int NODE_W   = 4;
    localparam int MASK_W   = 2 ** NODE_W;
    localparam int CNT_W    = NODE_W + 1;
    localparam int TICKET_W = 16;
    localparam int OP_W     = 2;
    localparam int KIND_W   = 2;
    localparam int DATA_W   = 24;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W    = 5;

    // Largest node count the design is built for, and the usable cap.
    localparam int MAX_NODES = 16;
    localparam int NODE_CAP  = (MAX_NODES < MASK_W) ? MAX_NODES : MASK_W;

    localparam logic [TICKET_W-1:0] TICKET_MAX = '1;
    localparam logic [CNT_W-1:0]    REPLY_SAT  = '1;

    // Input operation codes.
    localparam logic [OP_W-1:0] OP_LOCAL_REQ    = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOTE_REQ   = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOTE_REPLY = 2'd2;
    localparam logic [OP_W-1:0] OP_RELEASE      = 2'd3;

    // Output message kinds.
    localparam logic [KIND_W-1:0] KIND_REQUEST = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REPLY   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ENTER   = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'd1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take_item;
        logic scan_step;
    } tmx_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic start_scan;
        logic scan_last;
    } tmx_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/ticket_mutual_exclusion_node_unit.sv =====
// Ticket mutual exclusion node, one participant of the distributed protocol.
// An incoming request, reply or release that makes at most one outgoing word is taken one per
// cycle while the output word is consumed. A local request sends one request word to every
// other node of the clamped node count (to all of them when own_id lies outside that count);
// a release sends one reply word per deferred node. Burst words go out one per cycle while the
// output word is consumed. During such a burst the input is stalled: the node scan register
// drains through the single output word register before the next word is taken. Configuration
// goes in through cfg_wr_en/cfg_index/cfg_data; the user writes it only while the node is idle,
// which the block itself does not enforce. Builds on tmx_pkg, tmx_ctrl and tmx_dp.
`default_nettype none

module ticket_mutual_exclusion_node_unit
    import tmx_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Configuration write port.
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data,
    // Input word stream.
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [DATA_W-1:0]     s_tdata,   // [3:0] sender_node, [19:4] ticket_in
    input  wire logic [OP_W-1:0]       s_tuser,   // [1:0] opcode
    // Output word stream.
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [DATA_W-1:0]          m_tdata,   // [3:0] dest_node, [19:4] ticket_out
    output logic [KIND_W-1:0]          m_tuser,   // [1:0] msg_kind
    output logic                       m_tlast
);

    tmx_cmd_t              cmd;
    tmx_stat_t             stat;
    logic [NODE_W-1:0]     dest_node;
    logic [TICKET_W-1:0]   ticket_out;

    tmx_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tmx_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .opcode      (s_tuser),
        .sender_node (s_tdata[NODE_W-1:0]),
        .ticket_in   (s_tdata[NODE_W+TICKET_W-1:NODE_W]),
        .cmd         (cmd),
        .stat        (stat),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .msg_kind    (m_tuser),
        .dest_node   (dest_node),
        .ticket_out  (ticket_out),
        .last        (m_tlast)
    );

    // Pack the outgoing word, zero filled to whole bytes.
    assign m_tdata = {{(DATA_W - NODE_W - TICKET_W){1'b0}}, ticket_out, dest_node};

endmodule

`default_nettype wire

// ===== rtl/core/tmx_ctrl.sv =====
// Controller state machine for the ticket mutual exclusion node.
// Depends on tmx_pkg for the command and status structs.
`default_nettype none

module tmx_ctrl
    import tmx_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire tmx_stat_t stat,
    output tmx_cmd_t       cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t state_reg;
    state_t state_next;

    // A new word is taken only between bursts and when the output stage frees up.
    always_comb
    begin
        in_ready       = (state_reg == ST_IDLE) && stat.out_free;
        cmd.take_item  = in_valid && in_ready;
        cmd.scan_step  = (state_reg == ST_SCAN) && stat.out_free;
    end

    // Next state: enter the scan for a broadcast or release burst, leave on its last word.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.take_item && stat.start_scan)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (cmd.scan_step && stat.scan_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/tmx_dp.sv =====
// Datapath for the ticket mutual exclusion node: protocol state, the node
// scan register and the output word register. Depends on tmx_pkg.
`default_nettype none

module tmx_dp
    import tmx_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data,
    input  wire logic [OP_W-1:0]       opcode,
    input  wire logic [NODE_W-1:0]     sender_node,
    input  wire logic [TICKET_W-1:0]   ticket_in,
    input  wire tmx_cmd_t              cmd,
    output tmx_stat_t                  stat,
    input  wire logic                  out_ready,
    output logic                       out_valid,
    output logic [KIND_W-1:0]          msg_kind,
    output logic [NODE_W-1:0]          dest_node,
    output logic [TICKET_W-1:0]        ticket_out,
    output logic                       last
);

    // Configuration registers.
    logic [NODE_W-1:0]   own_id_reg;
    logic [CFG_W-1:0]    node_count_reg;

    // Protocol state.
    logic [TICKET_W-1:0] max_seen_reg;
    logic [TICKET_W-1:0] own_ticket_reg;
    logic                wanting_reg;
    logic                in_critical_reg;
    logic [CNT_W-1:0]    reply_count_reg;
    logic [MASK_W-1:0]   deferred_reg;

    // Burst scan: nodes still to be sent a word, with the kind and ticket to use.
    logic [MASK_W-1:0]   scan_mask_reg;
    logic [KIND_W-1:0]   scan_kind_reg;
    logic [TICKET_W-1:0] scan_ticket_reg;

    // Output word register.
    logic                out_valid_reg;
    logic [KIND_W-1:0]   out_kind_reg;
    logic [NODE_W-1:0]   out_dest_reg;
    logic [TICKET_W-1:0] out_ticket_reg;
    logic                out_last_reg;

    logic [CNT_W-1:0]    eff_count;
    logic [CNT_W-1:0]    needed;
    logic [MASK_W-1:0]   me_bit;
    logic [MASK_W-1:0]   bcast_mask;
    logic [MASK_W-1:0]   rel_mask;
    logic                valid_sender;
    logic [TICKET_W-1:0] new_ticket;
    logic [CNT_W-1:0]    count_inc;
    logic                reply_now;
    logic                defer_now;
    logic                grant_now;
    logic [MASK_W-1:0]   scan_clr;
    logic [NODE_W-1:0]   scan_idx;
    logic                start_scan;
    logic                scan_last;
    logic                out_free;

    // Effective node count, clamped to the supported range.
    always_comb
    begin
        if (node_count_reg < CNT_W'(2))
        begin
            eff_count = CNT_W'(2);
        end
        else if (node_count_reg > CNT_W'(NODE_CAP))
        begin
            eff_count = CNT_W'(NODE_CAP);
        end
        else
        begin
            eff_count = node_count_reg;
        end
    end

    // Replies needed, masks of broadcast targets and of deferred nodes to release.
    always_comb
    begin
        needed = ({1'b0, own_id_reg} < eff_count) ? eff_count - CNT_W'(1) : eff_count;
        me_bit = MASK_W'(1) << own_id_reg;
        for (int i = 0; i < MASK_W; i++)
        begin
            bcast_mask[i] = (CNT_W'(i) < eff_count);
        end
        bcast_mask = bcast_mask & ~me_bit;
        rel_mask   = deferred_reg & ~me_bit;
    end

    // Decode of the offered input word.
    always_comb
    begin
        valid_sender = ({1'b0, sender_node} < eff_count) && (sender_node != own_id_reg);
        new_ticket   = (max_seen_reg == TICKET_MAX) ? TICKET_MAX
                                                    : max_seen_reg + TICKET_W'(1);
        count_inc    = (reply_count_reg == REPLY_SAT) ? reply_count_reg
                                                      : reply_count_reg + CNT_W'(1);
        reply_now    = 1'b0;
        defer_now    = 1'b0;
        grant_now    = 1'b0;
        start_scan   = 1'b0;
        case (opcode)
            OP_LOCAL_REQ:
            begin
                start_scan = !wanting_reg && !in_critical_reg;
            end
            OP_REMOTE_REQ:
            begin
                if (valid_sender)
                begin
                    if (!wanting_reg || (ticket_in < own_ticket_reg) ||
                        ((ticket_in == own_ticket_reg) && (sender_node < own_id_reg)))
                    begin
                        reply_now = 1'b1;
                    end
                    else
                    begin
                        defer_now = 1'b1;
                    end
                end
            end
            OP_REMOTE_REPLY:
            begin
                grant_now = valid_sender && wanting_reg && !in_critical_reg &&
                            (count_inc >= needed);
            end
            OP_RELEASE:
            begin
                start_scan = in_critical_reg && (rel_mask != '0);
            end
            default:
            begin
                start_scan = 1'b0;
            end
        endcase
    end

    // Lowest pending node of the scan.
    always_comb
    begin
        scan_idx = '0;
        for (int i = MASK_W - 1; i >= 0; i--)
        begin
            if (scan_mask_reg[i])
            begin
                scan_idx = NODE_W'(i);
            end
        end
        scan_clr  = scan_mask_reg & (scan_mask_reg - MASK_W'(1));
        scan_last = (scan_clr == '0);
        out_free  = !out_valid_reg || out_ready;
    end

    // Status to the controller.
    always_comb
    begin
        stat.out_free   = out_free;
        stat.start_scan = start_scan;
        stat.scan_last  = scan_last;
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_id_reg     <= '0;
            node_count_reg <= CFG_W'(2);
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == CFG_OWN_ID)
            begin
                own_id_reg <= cfg_data[NODE_W-1:0];
            end
            else if (cfg_index == CFG_NODE_COUNT)
            begin
                node_count_reg <= cfg_data;
            end
        end
    end

    // Protocol state updates on an accepted word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_seen_reg    <= '0;
            own_ticket_reg  <= '0;
            wanting_reg     <= 1'b0;
            in_critical_reg <= 1'b0;
            reply_count_reg <= '0;
            deferred_reg    <= '0;
        end
        else if (cmd.take_item)
        begin
            case (opcode)
                OP_LOCAL_REQ:
                begin
                    if (!wanting_reg && !in_critical_reg)
                    begin
                        wanting_reg     <= 1'b1;
                        own_ticket_reg  <= new_ticket;
                        reply_count_reg <= '0;
                    end
                end
                OP_REMOTE_REQ:
                begin
                    if (valid_sender && (ticket_in > max_seen_reg))
                    begin
                        max_seen_reg <= ticket_in;
                    end
                    if (defer_now)
                    begin
                        deferred_reg <= deferred_reg | (MASK_W'(1) << sender_node);
                    end
                end
                OP_REMOTE_REPLY:
                begin
                    if (valid_sender && wanting_reg && !in_critical_reg)
                    begin
                        reply_count_reg <= count_inc;
                        if (grant_now)
                        begin
                            in_critical_reg <= 1'b1;
                        end
                    end
                end
                OP_RELEASE:
                begin
                    if (in_critical_reg)
                    begin
                        wanting_reg     <= 1'b0;
                        in_critical_reg <= 1'b0;
                        reply_count_reg <= '0;
                        deferred_reg    <= '0;
                    end
                end
                default:
                begin
                    wanting_reg <= wanting_reg;
                end
            endcase
        end
    end

    // Scan register: loaded when a burst starts, one node cleared per word sent.
    always_ff @(posedge clk)
    begin
        if (cmd.take_item && start_scan)
        begin
            if (opcode == OP_LOCAL_REQ)
            begin
                scan_mask_reg   <= bcast_mask;
                scan_kind_reg   <= KIND_REQUEST;
                scan_ticket_reg <= new_ticket;
            end
            else
            begin
                scan_mask_reg   <= rel_mask;
                scan_kind_reg   <= KIND_REPLY;
                scan_ticket_reg <= '0;
            end
        end
        else if (cmd.scan_step)
        begin
            scan_mask_reg <= scan_clr;
        end
    end

    // Output word register: valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.scan_step || (cmd.take_item && (reply_now || grant_now)))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output word register: payload.
    always_ff @(posedge clk)
    begin
        if (cmd.scan_step)
        begin
            out_kind_reg   <= scan_kind_reg;
            out_dest_reg   <= scan_idx;
            out_ticket_reg <= scan_ticket_reg;
            out_last_reg   <= scan_last;
        end
        else if (cmd.take_item && reply_now)
        begin
            out_kind_reg   <= KIND_REPLY;
            out_dest_reg   <= sender_node;
            out_ticket_reg <= '0;
            out_last_reg   <= 1'b1;
        end
        else if (cmd.take_item && grant_now)
        begin
            out_kind_reg   <= KIND_ENTER;
            out_dest_reg   <= '0;
            out_ticket_reg <= '0;
            out_last_reg   <= 1'b1;
        end
    end

    assign out_valid  = out_valid_reg;
    assign msg_kind   = out_kind_reg;
    assign dest_node  = out_dest_reg;
    assign ticket_out = out_ticket_reg;
    assign last       = out_last_reg;

endmodule

`default_nettype wire

// ===== rtl/core/tmx_checker.sv =====
// Port level checks for the ticket mutual exclusion node, bound to the top level.
// Depends on tmx_pkg for widths and message kinds.
`default_nettype none

module tmx_checker
    import tmx_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  cfg_wr_en,
    input wire logic [CFG_IDX_W-1:0]  cfg_index,
    input wire logic [CFG_W-1:0]      cfg_data,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic [DATA_W-1:0]     s_tdata,
    input wire logic [OP_W-1:0]       s_tuser,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [DATA_W-1:0]     m_tdata,
    input wire logic [KIND_W-1:0]     m_tuser,
    input wire logic                  m_tlast
);

    // A stalled output word stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
                                  $stable(m_tlast))
        else $error("output word changed while stalled");

    // An enter grant stands alone and carries no destination or ticket.
    a_enter_alone: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_ENTER) |-> m_tlast && (m_tdata == '0))
        else $error("enter grant malformed");

    // Replies carry a zero ticket.
    a_reply_ticket: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_REPLY) |-> (m_tdata[NODE_W+TICKET_W-1:NODE_W] == '0))
        else $error("reply with nonzero ticket");

    // While a broadcast is still running, no new input word is taken.
    a_burst_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_REQUEST) && !m_tlast |-> !s_tready)
        else $error("input taken during request broadcast");

endmodule

bind ticket_mutual_exclusion_node_unit tmx_checker u_tmx_checker (.*);

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking bench for ticket_mutual_exclusion_node_unit: a scripted opening, then random
// protocol traffic over several node settings, checked word by word against a behavioral model
// or the typed script rows' own words. Depends on tmx_pkg and the RTL of the node only.
module tb;
    import tmx_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 16;
    localparam int SCRIPT_ROWS  = 22;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 150;
    localparam int IDLE_LIMIT   = 3000;

    // One outgoing message word as the node should produce it.
    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [NODE_W-1:0]   dest;
        logic [TICKET_W-1:0] ticket;
        logic                last;
    } msg_t;

    // One row of the opening script; typed rows carry their own expected word.
    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [NODE_W-1:0]   sender;
        logic [TICKET_W-1:0] ticket;
        logic                typed;
        logic                has_msg;
        logic [KIND_W-1:0]   kind;
        logic [NODE_W-1:0]   dest;
        logic [TICKET_W-1:0] ticket_out;
    } script_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [DATA_W-1:0]    s_tdata;   // [3:0] sender_node, [19:4] ticket_in
    logic [OP_W-1:0]      s_tuser;   // [1:0] opcode
    logic                 m_tvalid;
    logic                 m_tready;
    logic [DATA_W-1:0]    m_tdata;   // [3:0] dest_node, [19:4] ticket_out
    logic [KIND_W-1:0]    m_tuser;   // [1:0] msg_kind
    logic                 m_tlast;

    // Model of the node: configuration and protocol state.
    logic [NODE_W-1:0]    node_id;
    logic [CNT_W-1:0]     node_total;
    logic [TICKET_W-1:0]  top_seen;
    logic [TICKET_W-1:0]  held_ticket;
    logic                 wants_entry;
    logic                 in_cs;
    logic [CNT_W-1:0]     grants_counted;
    logic [MASK_W-1:0]    deferred_mask;
    logic                 item_effective;

    msg_t                 fresh_msgs[$];
    msg_t                 pending_msgs[$];
    msg_t                 head_msg;
    script_row_t          script [SCRIPT_ROWS];

    int                   errors = 0;
    int                   burst_left = 0;
    int                   inputs_taken = 0;
    int                   idle_cycles = 0;
    int                   rx_cycle = 0;
    bit                   hold_done = 1'b0;

    int phase_own   [PHASES] = '{5, 15, 16, 9, 2, 31, 3, 7};
    int phase_count [PHASES] = '{8, 16, 31, 0, 1, 5, 16, 12};

    ticket_mutual_exclusion_node_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Node count in use: clamped to two at the bottom and to the id space at the top.
    function automatic int live_count();
        int n;
        n = node_total;
        if (n < 2)
            n = 2;
        if (n > NODE_CAP)
            n = NODE_CAP;
        return n;
    endfunction

    function automatic void add_msg(logic [KIND_W-1:0] kind, int dest,
                                    logic [TICKET_W-1:0] ticket);
        msg_t m;
        m.kind   = kind;
        m.dest   = dest[NODE_W-1:0];
        m.ticket = ticket;
        m.last   = 1'b0;
        fresh_msgs.push_back(m);
    endfunction

    // Advance the node model by one accepted word; its output words land in fresh_msgs.
    task automatic node_step(input logic [OP_W-1:0] op, input logic [NODE_W-1:0] sender,
                             input logic [TICKET_W-1:0] ticket);
        int   n;
        int   need;
        int   i;
        logic ok_sender;
        msg_t m;
        n = live_count();
        need = (node_id < n) ? n - 1 : n;
        ok_sender = (sender < n) && (sender != node_id);
        fresh_msgs.delete();
        item_effective = 1'b0;
        case (op)
            OP_LOCAL_REQ:
            begin
                if (!wants_entry && !in_cs)
                begin
                    item_effective = 1'b1;
                    wants_entry = 1'b1;
                    held_ticket = (top_seen == TICKET_MAX) ? TICKET_MAX : top_seen + 1'b1;
                    grants_counted = '0;
                    for (i = 0; i < n; i++)
                        if (i != node_id)
                            add_msg(KIND_REQUEST, i, held_ticket);
                end
            end
            OP_REMOTE_REQ:
            begin
                if (ok_sender)
                begin
                    item_effective = 1'b1;
                    if (ticket > top_seen)
                        top_seen = ticket;
                    if (!wants_entry || ticket < held_ticket ||
                        (ticket == held_ticket && sender < node_id))
                        add_msg(KIND_REPLY, sender, '0);
                    else
                        deferred_mask[sender] = 1'b1;
                end
            end
            OP_REMOTE_REPLY:
            begin
                if (ok_sender && wants_entry && !in_cs)
                begin
                    item_effective = 1'b1;
                    if (grants_counted != REPLY_SAT)
                        grants_counted = grants_counted + 1'b1;
                    if (grants_counted >= need)
                    begin
                        in_cs = 1'b1;
                        add_msg(KIND_ENTER, 0, '0);
                    end
                end
            end
            default:
            begin
                if (in_cs)
                begin
                    item_effective = 1'b1;
                    wants_entry = 1'b0;
                    in_cs = 1'b0;
                    grants_counted = '0;
                    for (i = 0; i < MASK_W; i++)
                        if (i != node_id && deferred_mask[i])
                            add_msg(KIND_REPLY, i, '0);
                    deferred_mask = '0;
                end
            end
        endcase
        if (fresh_msgs.size() > 0)
        begin
            m = fresh_msgs[fresh_msgs.size() - 1];
            m.last = 1'b1;
            fresh_msgs[fresh_msgs.size() - 1] = m;
        end
    endtask

    // Offer one word in bursts with random gaps, wait for acceptance, then update the model.
    task automatic send_word(input logic [OP_W-1:0] op, input logic [NODE_W-1:0] sender,
                             input logic [TICKET_W-1:0] ticket);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(DATA_W - TICKET_W - NODE_W){1'b0}}, ticket, sender};
        do
            @(posedge clk);
        while (!s_tready);
        inputs_taken++;
        node_step(op, sender, ticket);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_W-1:0];
        @(posedge clk);
        if (idx == CFG_OWN_ID)
            node_id = value[NODE_W-1:0];
        else
            node_total = value[CNT_W-1:0];
    endtask

    // Wait until every expected word has come, then let the pipeline run dry.
    task automatic settle();
        while (pending_msgs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Pick the next random word: mostly protocol steps that fit the node's state,
    // with a share of arbitrary words on top.
    task automatic pick_word(input bit ceiling, output logic [OP_W-1:0] op,
                             output logic [NODE_W-1:0] sender,
                             output logic [TICKET_W-1:0] ticket);
        int n;
        int r;
        int s;
        n = live_count();
        r = $urandom_range(0, 99);
        do
            s = $urandom_range(0, n - 1);
        while (s == node_id);
        sender = s[NODE_W-1:0];
        case ($urandom_range(0, 3))
            0:       ticket = held_ticket;
            1:       ticket = held_ticket - 1'b1;
            2:       ticket = held_ticket + 1'b1;
            default: ticket = top_seen + TICKET_W'($urandom_range(0, 3));
        endcase
        if (ceiling)
            ticket = ($urandom_range(0, 3) == 0) ? TICKET_MAX
                                                 : TICKET_W'($urandom_range(16'hFFF8, 16'hFFFF));
        if (in_cs)
            op = (r < 35) ? OP_RELEASE : OP_REMOTE_REQ;
        else if (wants_entry)
            op = (r < 55) ? OP_REMOTE_REPLY : OP_REMOTE_REQ;
        else
            op = (r < 40) ? OP_LOCAL_REQ : OP_REMOTE_REQ;
        if (r >= 80)
        begin
            op     = OP_W'($urandom_range(0, 3));
            sender = NODE_W'($urandom_range(0, 15));
            ticket = TICKET_W'($urandom_range(0, 16'hFFFF));
        end
    endtask

    // Receiver: ready pattern that cycles through modes, plus one long hold-off.
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rx_cycle++;
            if (!hold_done && inputs_taken >= 60)
            begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                case (rx_cycle[7:6])
                    2'd0:    m_tready <= 1'b1;
                    2'd1:    m_tready <= ($urandom_range(0, 3) != 0);
                    2'd2:    m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= (rx_cycle[2:0] != 3'd0);
                endcase
            end
        end
    end

    // Compare each accepted output word with the oldest expected one.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_msgs.size() == 0)
            begin
                $error("unexpected word: kind %0d dest %0d ticket %0d last %0b",
                       m_tuser, m_tdata[3:0], m_tdata[19:4], m_tlast);
                errors++;
            end
            else
            begin
                head_msg = pending_msgs.pop_front();
                if (m_tuser !== head_msg.kind)
                begin
                    $error("msg_kind: expected %0d, got %0d", head_msg.kind, m_tuser);
                    errors++;
                end
                if (m_tdata[3:0] !== head_msg.dest)
                begin
                    $error("dest_node: expected %0d, got %0d", head_msg.dest, m_tdata[3:0]);
                    errors++;
                end
                if (m_tdata[19:4] !== head_msg.ticket)
                begin
                    $error("ticket_out: expected %0d, got %0d", head_msg.ticket,
                           m_tdata[19:4]);
                    errors++;
                end
                if (m_tdata[DATA_W-1:20] !== '0)
                begin
                    $error("tdata padding: expected 0, got %0h", m_tdata[DATA_W-1:20]);
                    errors++;
                end
                if (m_tlast !== head_msg.last)
                begin
                    $error("last: expected %0b, got %0b", head_msg.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Main sequence: reset, scripted opening, then random phases over several settings.
    initial
    begin
        int               row;
        int               ph;
        int               taken;
        logic [OP_W-1:0]     op;
        logic [NODE_W-1:0]   sender;
        logic [TICKET_W-1:0] ticket;
        msg_t             m;

        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= OP_LOCAL_REQ;
        cfg_wr_en <= 1'b0;
        cfg_index <= CFG_OWN_ID;
        cfg_data  <= '0;

        node_id        = '0;
        node_total     = 5'd2;
        top_seen       = '0;
        held_ticket    = '0;
        wants_entry    = 1'b0;
        in_cs          = 1'b0;
        grants_counted = '0;
        deferred_mask  = '0;

        // Opening script at the reset settings: own id 0, two nodes.
        script = '{
            // Release, reply and foreign requests that must be ignored.
            '{OP_RELEASE,      4'd0,  16'd0,      1'b1, 1'b0, KIND_REQUEST, 4'd0, 16'd0},
            '{OP_REMOTE_REPLY, 4'd1,  16'd0,      1'b1, 1'b0, KIND_REQUEST, 4'd0, 16'd0},
            '{OP_REMOTE_REQ,   4'd0,  16'hFFFF,   1'b1, 1'b0, KIND_REQUEST, 4'd0, 16'd0},
            '{OP_REMOTE_REQ,   4'd15, 16'hFFFF,   1'b1, 1'b0, KIND_REQUEST, 4'd0, 16'd0},
            // Idle node answers a request at once.
            '{OP_REMOTE_REQ,   4'd1,  16'd0,      1'b1, 1'b1, KIND_REPLY,   4'd1, 16'd0},
            '{OP_LOCAL_REQ,    4'd0,  16'd0,      1'b1, 1'b1, KIND_REQUEST, 4'd1, 16'd1},
            '{OP_LOCAL_REQ,    4'd3,  16'd9,      1'b1, 1'b0, KIND_REQUEST, 4'd0, 16'd0},
            // Equal ticket, larger sender id: deferred.
            '{OP_REMOTE_REQ,   4'd1,  16'd1,      1'b0, 1'b0, KIND_REQUEST, 4'd0, 16'd0},
            '{OP_REMOTE_REQ,   4'd1,  16'd0,      1'b1, 1'b1, KIND_REPLY,   4'd1, 16'd0},
            '{OP_REMOTE_REPLY, 4'd1,  16'd0,      1'b1, 1'b1, KIND_ENTER,   4'd0, 16'd0},
            '{OP_REMOTE_REPLY, 4'd1,  16'd0,      1'b1, 1'b0, KIND_REQUEST, 4'd0, 16'd0},
            '{OP_LOCAL_REQ,    4'd0,  16'd0,      1'b1, 1'b0, KIND_REQUEST, 4'd0, 16'd0},
            '{OP_REMOTE_REQ,   4'd1,  16'd5,      1'b1, 1'b0, KIND_REQUEST, 4'd0, 16'd0},
            '{OP_RELEASE,      4'd0,  16'd0,      1'b1, 1'b1, KIND_REPLY,   4'd1, 16'd0},
            '{OP_LOCAL_REQ,    4'd0,  16'd0,      1'b1, 1'b1, KIND_REQUEST, 4'd1, 16'd6},
            '{OP_REMOTE_REQ,   4'd1,  16'd6,      1'b0, 1'b0, KIND_REQUEST, 4'd0, 16'd0},
            '{OP_REMOTE_REPLY, 4'd1,  16'd0,      1'b1, 1'b1, KIND_ENTER,   4'd0, 16'd0},
            '{OP_RELEASE,      4'd0,  16'd0,      1'b1, 1'b1, KIND_REPLY,   4'd1, 16'd0},
            // Ticket field of a local request carries no meaning.
            '{OP_LOCAL_REQ,    4'd15, 16'hFFFF,   1'b1, 1'b1, KIND_REQUEST, 4'd1, 16'd7},
            '{OP_RELEASE,      4'd0,  16'd0,      1'b1, 1'b0, KIND_REQUEST, 4'd0, 16'd0},
            '{OP_REMOTE_REPLY, 4'd1,  16'd0,      1'b1, 1'b1, KIND_ENTER,   4'd0, 16'd0},
            // Release with nothing deferred sends nothing.
            '{OP_RELEASE,      4'd0,  16'd0,      1'b1, 1'b0, KIND_REQUEST, 4'd0, 16'd0}
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (row = 0; row < SCRIPT_ROWS; row++)
        begin
            send_word(script[row].op, script[row].sender, script[row].ticket);
            if (script[row].typed)
            begin
                if (script[row].has_msg)
                begin
                    m.kind   = script[row].kind;
                    m.dest   = script[row].dest;
                    m.ticket = script[row].ticket_out;
                    m.last   = 1'b1;
                    pending_msgs.push_back(m);
                end
            end
            else
            begin
                foreach (fresh_msgs[i])
                    pending_msgs.push_back(fresh_msgs[i]);
            end
        end
        s_tvalid <= 1'b0;
        settle();

        // Random traffic; the last phase drives tickets up to saturation.
        for (ph = 0; ph < PHASES; ph++)
        begin
            cfg_write(CFG_OWN_ID, phase_own[ph]);
            cfg_write(CFG_NODE_COUNT, phase_count[ph]);
            cfg_wr_en <= 1'b0;
            taken = 0;
            while (taken < PHASE_ITEMS)
            begin
                pick_word(ph == PHASES - 1, op, sender, ticket);
                send_word(op, sender, ticket);
                foreach (fresh_msgs[i])
                    pending_msgs.push_back(fresh_msgs[i]);
                if (item_effective)
                    taken++;
            end
            s_tvalid <= 1'b0;
            settle();
        end

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
